// ===== src/vgmcsc_pkg.sv =====
`default_nettype none

package vgmcsc_pkg;

   typedef logic [32:0] pos_type;

   // command codes
   localparam logic [7:0] CmdRegWrite   = 8'h54;
   localparam logic [7:0] CmdWaitSample = 8'h61;
   localparam logic [7:0] CmdWaitFrame  = 8'h62;
   localparam logic [7:0] CmdEnd        = 8'h66;
   localparam logic [7:0] CmdSkipThree  = 8'hC0;
   localparam logic [7:0] CmdDataBlock  = 8'h67;

   // "Vgm " in file order, byte 0 in the low lane
   localparam logic [31:0] FileSignature = 32'h206D_6756;

   localparam pos_type LoopField    = 33'h1C;
   localparam pos_type DataField    = 33'h34;
   localparam pos_type DataStartMin = 33'h38;
   localparam pos_type SigLastPos   = 33'h3;

   // samples / 735 == (samples * 91305) >> 26 for every 16-bit sample count
   localparam logic [16:0] WaitRecip = 17'd91305;
   localparam int unsigned WaitShift = 26;

   // csr register indexes
   localparam logic CsrDoneCode  = 1'b0;
   localparam logic CsrDelayCode = 1'b1;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] out_reg;
      logic [7:0] out_value;
      logic       status;
      logic       run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// ===== src/vgm_command_stream_converter_top.sv =====
`default_nettype none

// Channel   Direction  Handshake             Beat payload
// req       in         req_valid/req_stall   req_func, req_in_byte
// rsp       out        rsp_valid/rsp_stall   rsp_out_reg, rsp_out_value, rsp_status,
//                                            rsp_run_last
// csr       in         csr_wr_en             csr_index, csr_wr_data (no read-back)
//
// One file byte is parsed per cycle while req_stall is low: a req beat updates
// the parse state in the same cycle and writes its zero, one or two result beats
// into a 4-entry queue. The first rsp beat can leave the cycle after the req beat.
// req_stall rises only when the queue holds more than two beats, so with rsp_stall
// low the block takes a byte every cycle; the two beats of one byte leave in turn.
// Synchronous reset returns to the signature check at file position 0.

module vgm_command_stream_converter_top
   import vgmcsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_func,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_reg,
   output logic [7:0]      rsp_out_value,
   output logic            rsp_status,
   output logic            rsp_run_last,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wr_data
);

   typedef enum logic [2:0] {
      PhHeader,
      PhGap,
      PhCmd,
      PhRegPair,
      PhWait,
      PhBlock,
      PhSkip
   } phase_type;

   // parse state
   pos_type     pos_ff,       pos_in;
   pos_type     loop_pos_ff,  loop_pos_in;
   pos_type     data_start_ff, data_start_in;
   phase_type   phase_ff,     phase_in;
   logic [23:0] operand_ff,   operand_in;
   logic [2:0]  opcnt_ff,     opcnt_in;
   logic [31:0] skip_ff,      skip_in;
   logic        finished_ff,  finished_in;
   logic        sig_bad_ff,   sig_bad_in;
   logic [7:0]  done_code_ff, done_code_in;
   logic [7:0]  delay_code_ff, delay_code_in;

   logic        accept;
   logic        room_short;
   phase_type   phase_now;
   logic        marker_hit;
   result_type  marker_res;
   logic        cmd_hit;
   result_type  cmd_res;
   push_type    push;
   result_type  head;
   logic [15:0] samples;
   logic [32:0] wait_product;
   logic        sig_mismatch;
   pos_type     field_sum;
   logic [31:0] block_len;

   function automatic logic [23:0] insert_byte(input logic [23:0] word,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  data);
      logic [23:0] r;
      r = word;
      case (lane)
         2'd0:    r[7:0]   = data;
         2'd1:    r[15:8]  = data;
         2'd2:    r[23:16] = data;
         default: r = word;
      endcase
      return r;
   endfunction

   assign req_stall = room_short;
   assign accept    = req_valid && !req_stall;

   // delay ticks: 16-bit sample count over 735 by reciprocal
   assign samples      = {req_in_byte, operand_ff[7:0]};
   assign wait_product = 33'(samples) * 33'(WaitRecip);

   assign sig_mismatch = sig_bad_ff ||
                         (req_in_byte != FileSignature[8*pos_ff[1:0] +: 8]);
   // header fields are little-endian, byte 3 arrives last
   assign field_sum    = {1'b0, req_in_byte, operand_ff} +
                         ((pos_ff[5:0] == 6'h37) ? DataField : LoopField);
   assign block_len    = {req_in_byte, operand_ff};

   // a gap byte at or past the data start is the first command
   assign phase_now = (phase_ff == PhGap && pos_ff >= data_start_ff) ? PhCmd : phase_ff;

   always_comb begin
      pos_in        = pos_ff;
      loop_pos_in   = loop_pos_ff;
      data_start_in = data_start_ff;
      phase_in      = phase_ff;
      operand_in    = operand_ff;
      opcnt_in      = opcnt_ff;
      skip_in       = skip_ff;
      finished_in   = finished_ff;
      sig_bad_in    = sig_bad_ff;
      done_code_in  = done_code_ff;
      delay_code_in = delay_code_ff;
      marker_hit    = 1'b0;
      marker_res    = '{out_reg: done_code_ff, out_value: 8'd0, status: 1'b0, run_last: 1'b0};
      cmd_hit       = 1'b0;
      cmd_res       = '{out_reg: done_code_ff, out_value: 8'd0, status: 1'b0, run_last: 1'b0};

      if (csr_wr_en) begin
         unique case (csr_index)
            CsrDoneCode:  done_code_in  = csr_wr_data;
            CsrDelayCode: delay_code_in = csr_wr_data;
            default:      done_code_in  = done_code_ff;
         endcase
      end

      if (accept && !finished_ff) begin
         if (req_func) begin
            // end of stream; a short file still gets a done beat
            finished_in = 1'b1;
            if (pos_ff <= SigLastPos) begin
               cmd_hit = 1'b1;
            end
         end else begin
            pos_in   = pos_ff + 33'd1;
            phase_in = phase_now;
            unique case (phase_now)
               PhHeader: begin
                  if (pos_ff <= SigLastPos) begin
                     sig_bad_in = sig_mismatch;
                     if (pos_ff == SigLastPos && sig_mismatch) begin
                        cmd_hit     = 1'b1;
                        cmd_res     = '{out_reg: 8'd0, out_value: 8'd0, status: 1'b1,
                                        run_last: 1'b0};
                        finished_in = 1'b1;
                     end
                  end else if ((pos_ff >= LoopField && pos_ff < LoopField + 33'd4) ||
                               (pos_ff >= DataField && pos_ff < DataField + 33'd4)) begin
                     operand_in = insert_byte(operand_ff, pos_ff[1:0], req_in_byte);
                     if (pos_ff == LoopField + 33'd3) begin
                        loop_pos_in = field_sum;
                     end
                     if (pos_ff == DataField + 33'd3) begin
                        data_start_in = (field_sum < DataStartMin) ? DataStartMin : field_sum;
                        phase_in      = PhGap;
                     end
                  end
               end
               PhGap: begin
                  phase_in = PhGap;
               end
               PhRegPair: begin
                  if (opcnt_ff == 3'd0) begin
                     operand_in = {16'd0, req_in_byte};
                     opcnt_in   = 3'd1;
                  end else begin
                     cmd_hit  = 1'b1;
                     cmd_res  = '{out_reg: operand_ff[7:0], out_value: req_in_byte,
                                  status: 1'b0, run_last: 1'b0};
                     phase_in = PhCmd;
                  end
               end
               PhWait: begin
                  if (opcnt_ff == 3'd0) begin
                     operand_in = {16'd0, req_in_byte};
                     opcnt_in   = 3'd1;
                  end else begin
                     cmd_hit  = 1'b1;
                     cmd_res  = '{out_reg: delay_code_ff,
                                  out_value: 8'(wait_product >> WaitShift),
                                  status: 1'b0, run_last: 1'b0};
                     phase_in = PhCmd;
                  end
               end
               PhBlock: begin
                  // two header bytes, then a 4-byte length
                  if (opcnt_ff >= 3'd2 && opcnt_ff <= 3'd4) begin
                     operand_in = insert_byte(operand_ff, 2'(opcnt_ff - 3'd2), req_in_byte);
                  end
                  if (opcnt_ff >= 3'd5) begin
                     skip_in  = block_len;
                     phase_in = (block_len == 32'd0) ? PhCmd : PhSkip;
                  end else begin
                     opcnt_in = opcnt_ff + 3'd1;
                  end
               end
               PhSkip: begin
                  skip_in = skip_ff - 32'(skip_ff != 32'd0);
                  if (skip_in == 32'd0) begin
                     phase_in = PhCmd;
                  end
               end
               PhCmd: begin
                  marker_hit = (pos_ff == loop_pos_ff);
                  operand_in = '0;
                  opcnt_in   = 3'd0;
                  unique case (req_in_byte)
                     CmdRegWrite:   phase_in = PhRegPair;
                     CmdWaitSample: phase_in = PhWait;
                     CmdWaitFrame: begin
                        cmd_hit = 1'b1;
                        cmd_res = '{out_reg: delay_code_ff, out_value: 8'd1,
                                    status: 1'b0, run_last: 1'b0};
                     end
                     CmdEnd: begin
                        cmd_hit     = 1'b1;
                        finished_in = 1'b1;
                     end
                     CmdSkipThree: begin
                        phase_in = PhSkip;
                        skip_in  = 32'd3;
                     end
                     CmdDataBlock:  phase_in = PhBlock;
                     default:       phase_in = PhCmd;
                  endcase
               end
               default: phase_in = PhCmd;
            endcase
         end
      end

      // pack beats in order, flag the last one
      push.count  = 2'(marker_hit) + 2'(cmd_hit);
      push.first  = marker_hit ? marker_res : cmd_res;
      push.second = cmd_res;
      if (push.count == 2'd2) begin
         push.second.run_last = 1'b1;
      end else begin
         push.first.run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         loop_pos_ff   <= '0;
         data_start_ff <= '0;
         phase_ff      <= PhHeader;
         operand_ff    <= '0;
         opcnt_ff      <= '0;
         skip_ff       <= '0;
         finished_ff   <= 1'b0;
         sig_bad_ff    <= 1'b0;
         done_code_ff  <= 8'd0;
         delay_code_ff <= 8'd1;
      end else begin
         pos_ff        <= pos_in;
         loop_pos_ff   <= loop_pos_in;
         data_start_ff <= data_start_in;
         phase_ff      <= phase_in;
         operand_ff    <= operand_in;
         opcnt_ff      <= opcnt_in;
         skip_ff       <= skip_in;
         finished_ff   <= finished_in;
         sig_bad_ff    <= sig_bad_in;
         done_code_ff  <= done_code_in;
         delay_code_ff <= delay_code_in;
      end
   end

   vgmcsc_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_short (room_short),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   assign rsp_out_reg   = head.out_reg;
   assign rsp_out_value = head.out_value;
   assign rsp_status    = head.status;
   assign rsp_run_last  = head.run_last;

endmodule

`default_nettype wire

// ===== src/vgmcsc_result_queue.sv =====
`default_nettype none

module vgmcsc_result_queue
   import vgmcsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            room_short,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      head
);

   result_type               mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]     wr_ptr_ff;
   logic [QueuePtrW-1:0]     rd_ptr_ff;
   logic [QueueCntW-1:0]     count_ff;
   logic                     pop;
   logic [QueuePtrW-1:0]     wr_next_ptr;

   assign rsp_valid   = (count_ff != '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign head        = mem_ff[rd_ptr_ff];
   // need space for two beats before taking another item
   assign room_short  = (count_ff > QueueCntW'(QueueDepth - 2));
   assign wr_next_ptr = wr_ptr_ff + QueuePtrW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QueuePtrW'(push.count);
         rd_ptr_ff <= rd_ptr_ff + QueuePtrW'(pop);
         count_ff  <= count_ff + QueueCntW'(push.count) - QueueCntW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next_ptr] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import vgmcsc_pkg::*;

   localparam int HalfPeriod     = 2;
   localparam int ResetCycles    = 12;
   localparam int DrainCycles    = 8;     // idle tail after the last owed beat
   localparam int WatchdogLimit  = 1000;  // cycles without any accepted beat
   localparam int PhaseBeats     = 450;
   localparam int NoiseBeats     = 24;
   localparam int unsigned SamplesPerTick = 735;

   // directed command run placed right after the header
   localparam int DirectedLen = 41;
   localparam logic [7:0] DirectedBytes [DirectedLen] = '{
      CmdRegWrite, 8'h00, 8'h00,
      CmdRegWrite, 8'hFF, 8'hFF,
      CmdWaitSample, 8'h00, 8'h00,
      CmdWaitSample, 8'hDE, 8'h02,                      // 734 samples -> 0 ticks
      CmdWaitSample, 8'hDF, 8'h02,                      // 735 samples -> 1 tick
      CmdWaitSample, 8'hFF, 8'hFF,
      CmdWaitFrame,
      CmdSkipThree, CmdEnd, CmdRegWrite, CmdWaitSample,  // codes inside skip are data
      CmdDataBlock, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  // empty block
      CmdDataBlock, 8'h66, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, CmdEnd, CmdWaitFrame,
      8'h00, 8'hFF                                      // unknown one-byte codes
   };

   typedef enum logic [2:0] {
      ParseHeader, ParseGap, ParseCmd, ParseRegPair, ParseWait, ParseBlock, ParseSkip
   } parse_type;

   typedef enum logic [1:0] {PlanFullFile, PlanBadSignature, PlanShortStream} plan_type;

   // ------------------------------------------------------------------
   // Pair predictor and scoreboard: follows the file parse byte by byte
   // and keeps the pairs still owed by the block, oldest first.
   // ------------------------------------------------------------------
   class pair_ledger_type;
      pos_type     byte_pos;
      pos_type     loop_pos;
      pos_type     data_start;
      parse_type   phase;
      logic [23:0] operand;
      logic [2:0]  operand_cnt;
      logic [31:0] skip_left;
      bit          finished;
      logic [7:0]  done_code;
      logic [7:0]  delay_code;
      result_type  fresh[$];
      result_type  pairs_due[$];
      int          errors;

      function new();
         byte_pos    = '0;
         loop_pos    = '0;
         data_start  = '0;
         phase       = ParseHeader;
         operand     = '0;
         operand_cnt = '0;
         skip_left   = '0;
         finished    = 1'b0;
         done_code   = 8'h00;
         delay_code  = 8'h01;
         errors      = 0;
      endfunction

      function void set_code(logic index, logic [7:0] value);
         if (index == CsrDoneCode) done_code = value;
         else delay_code = value;
      endfunction

      function void add_pair(logic [7:0] r, logic [7:0] v, logic st);
         result_type pr;
         pr.out_reg   = r;
         pr.out_value = v;
         pr.status    = st;
         pr.run_last  = 1'b0;
         fresh.push_back(pr);
      endfunction

      function void note_byte(logic f, logic [7:0] b);
         pos_type     p;
         int unsigned samples;
         result_type  pr;
         if (finished) return;
         fresh.delete();
         p = byte_pos;
         if (f) begin
            // end of stream: only a stream cut inside the signature reports
            if (p <= SigLastPos) add_pair(done_code, 8'h00, 1'b0);
            finished = 1'b1;
         end else begin
            byte_pos = p + 1'b1;
            if (phase == ParseGap && p >= data_start) phase = ParseCmd;
            case (phase)
               ParseHeader: begin
                  if (p <= SigLastPos) begin
                     if (b != FileSignature[{p[1:0], 3'b000} +: 8]) operand = 24'd1;
                     if (p == SigLastPos && operand != 0) begin
                        add_pair(8'h00, 8'h00, 1'b1);
                        finished = 1'b1;
                     end
                  end else if (p >= LoopField && p < LoopField + 4) begin
                     if (p == LoopField) loop_pos = LoopField;
                     loop_pos += pos_type'(b) << {p[1:0], 3'b000};
                  end else if (p >= DataField && p < DataField + 4) begin
                     if (p == DataField) data_start = DataField;
                     data_start += pos_type'(b) << {p[1:0], 3'b000};
                     if (p == DataField + 3) begin
                        if (data_start < DataStartMin) data_start = DataStartMin;
                        phase = ParseGap;
                     end
                  end
               end
               ParseGap: ;
               ParseRegPair: begin
                  if (operand_cnt == 0) begin
                     operand     = {16'h0, b};
                     operand_cnt = 3'd1;
                  end else begin
                     add_pair(operand[7:0], b, 1'b0);
                     phase = ParseCmd;
                  end
               end
               ParseWait: begin
                  if (operand_cnt == 0) begin
                     operand     = {16'h0, b};
                     operand_cnt = 3'd1;
                  end else begin
                     samples = {b, operand[7:0]};
                     samples = samples / SamplesPerTick;
                     add_pair(delay_code, samples[7:0], 1'b0);
                     phase = ParseCmd;
                  end
               end
               ParseBlock: begin
                  // type byte, tag byte, then a 32-bit little-endian length
                  if (operand_cnt >= 2 && operand_cnt <= 4)
                     operand |= 24'(b) << (8 * (operand_cnt - 2));
                  if (operand_cnt >= 5) begin
                     skip_left = {b, operand};
                     phase = (skip_left == 0) ? ParseCmd : ParseSkip;
                  end else begin
                     operand_cnt++;
                  end
               end
               ParseSkip: begin
                  if (skip_left > 0) skip_left--;
                  if (skip_left == 0) phase = ParseCmd;
               end
               default: begin
                  if (p == loop_pos) add_pair(done_code, 8'h00, 1'b0);
                  operand     = '0;
                  operand_cnt = '0;
                  case (b)
                     CmdRegWrite:   phase = ParseRegPair;
                     CmdWaitSample: phase = ParseWait;
                     CmdWaitFrame:  add_pair(delay_code, 8'h01, 1'b0);
                     CmdEnd: begin
                        add_pair(done_code, 8'h00, 1'b0);
                        finished = 1'b1;
                     end
                     CmdSkipThree: begin
                        phase     = ParseSkip;
                        skip_left = 32'd3;
                     end
                     CmdDataBlock:  phase = ParseBlock;
                     default: ;
                  endcase
               end
            endcase
         end
         foreach (fresh[i]) begin
            pr = fresh[i];
            pr.run_last = (i == fresh.size() - 1);
            pairs_due.push_back(pr);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pairs_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, actual reg %h value %h status %b last %b",
                     $time, got.out_reg, got.out_value, got.status, got.run_last);
            return;
         end
         want = pairs_due.pop_front();
         compare_field("out_reg", want.out_reg, got.out_reg);
         compare_field("out_value", want.out_value, got.out_value);
         compare_field("status", want.status, got.status);
         compare_field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_func    = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       csr_wr_en   = 1'b0;
   logic       csr_index   = CsrDoneCode;
   logic [7:0] csr_wr_data = 8'h00;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_reg;
   logic [7:0] rsp_out_value;
   logic       rsp_status;
   logic       rsp_run_last;

   vgm_command_stream_converter_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_reg   (rsp_out_reg),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .rsp_run_last  (rsp_run_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   pair_ledger_type ledger = new();

   int         send_idle_pct = 0;  // chance per beat slot that the sender holds off
   int         stall_pct     = 0;  // chance per cycle that the receiver stalls
   int         beats_sent    = 0;
   int         quiet_cycles  = 0;
   plan_type   plan;
   bit         file_done     = 1'b0;  // stream has been ended or rejected
   pos_type    sent_pos      = '0;    // file position of the next data byte
   pos_type    loop_target   = '0;
   bit         loop_armed    = 1'b0;  // loop offset points at a planned command
   logic [7:0] cmd_bytes[$];

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

   // Monitor: both channels sampled at the edge where the beat moves. The input
   // beat is noted before the result check so a same-edge result still finds
   // its expectation. Watchdog trips when nothing moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_byte(req_func, req_in_byte);
         if (rsp_valid && !rsp_stall)
            ledger.check_result({rsp_out_reg, rsp_out_value, rsp_status, rsp_run_last});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // One input beat; holds the payload until the block takes it.
   task automatic send_beat(input logic f, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      beats_sent++;
      if (!f) sent_pos++;
   endtask

   task automatic write_codes(input logic [7:0] done_val, input logic [7:0] delay_val);
      csr_wr_en   <= 1'b1;
      csr_index   <= CsrDoneCode;
      csr_wr_data <= done_val;
      @(posedge clock);
      ledger.set_code(CsrDoneCode, done_val);
      csr_index   <= CsrDelayCode;
      csr_wr_data <= delay_val;
      @(posedge clock);
      ledger.set_code(CsrDelayCode, delay_val);
      csr_wr_en   <= 1'b0;
   endtask

   // Drop valid and wait out every owed pair plus the pipeline tail.
   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.pairs_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_unknown();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CmdRegWrite || b == CmdWaitSample || b == CmdWaitFrame ||
             b == CmdEnd || b == CmdSkipThree || b == CmdDataBlock);
      return b;
   endfunction

   // Signature, header fields and the gap up to the data start. The bad
   // signature and short stream plans end the file here.
   task automatic send_header();
      logic [31:0] loop_field;
      logic [31:0] data_field;
      pos_type     data_at;
      logic [7:0]  b;
      int          lane;
      int          pick;
      if (plan == PlanShortStream) begin
         lane = $urandom_range(0, 3);
         for (int i = 0; i < lane; i++) send_beat(1'b0, FileSignature[8 * i +: 8]);
         send_beat(1'b1, 8'($urandom));
         file_done = 1'b1;
         return;
      end
      lane = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         b = FileSignature[8 * i +: 8];
         if (plan == PlanBadSignature && i == lane) b ^= 8'($urandom_range(1, 255));
         send_beat(1'b0, b);
      end
      if (plan == PlanBadSignature) begin
         file_done = 1'b1;
         return;
      end

      // small offsets land below the minimum data start and get clamped
      data_field = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 44);
      data_at = DataField + data_field;
      if (data_at < DataStartMin) data_at = DataStartMin;

      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         loop_target = data_at + DirectedLen + $urandom_range(0, 200);
         loop_field  = 32'(loop_target - LoopField);
         loop_armed  = 1'b1;
      end else if (pick < 8) begin
         loop_field = $urandom_range(0, 27);  // inside the header, never hit
      end else begin
         loop_field = {8'($urandom_range(1, 255)), 24'($urandom)};  // beyond the run
      end

      for (int p = 4; p < int'(data_at); p++) begin
         b = 8'($urandom);
         if (p >= int'(LoopField) && p < int'(LoopField) + 4)
            b = loop_field[8 * (p - int'(LoopField)) +: 8];
         if (p >= int'(DataField) && p < int'(DataField) + 4)
            b = data_field[8 * (p - int'(DataField)) +: 8];
         send_beat(1'b0, b);
      end
   endtask

   // Random command with random content into cmd_bytes.
   task automatic build_command();
      int pick;
      int len;
      cmd_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         cmd_bytes.push_back(CmdRegWrite);
         cmd_bytes.push_back(8'($urandom));
         cmd_bytes.push_back(8'($urandom));
      end else if (pick < 46) begin
         cmd_bytes.push_back(CmdWaitSample);
         cmd_bytes.push_back(8'($urandom));
         cmd_bytes.push_back(8'($urandom));
      end else if (pick < 58) begin
         cmd_bytes.push_back(CmdWaitFrame);
      end else if (pick < 66) begin
         cmd_bytes.push_back(CmdSkipThree);
         repeat (3) cmd_bytes.push_back(8'($urandom));
      end else if (pick < 73) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
         cmd_bytes.push_back(CmdDataBlock);
         cmd_bytes.push_back(8'($urandom));
         cmd_bytes.push_back(8'($urandom));
         cmd_bytes.push_back(8'(len));
         repeat (3) cmd_bytes.push_back(8'h00);
         repeat (len) cmd_bytes.push_back(8'($urandom));
      end else if (pick < 90) begin
         cmd_bytes.push_back(pick_unknown());
      end else begin
         // noise: any byte but the end code, may swallow the next command
         do len = $urandom_range(0, 255);
         while (len == CmdEnd);
         cmd_bytes.push_back(8'(len));
      end
   endtask

   // Sends cmd_bytes; if the loop offset falls inside it, one-byte fillers go
   // first so that a command starts exactly there.
   task automatic emit_command();
      if (loop_armed && sent_pos < loop_target && sent_pos + cmd_bytes.size() > loop_target)
         while (sent_pos < loop_target) send_beat(1'b0, pick_unknown());
      foreach (cmd_bytes[i]) send_beat(1'b0, cmd_bytes[i]);
   endtask

   task automatic feed_random(input int beats);
      int start;
      start = beats_sent;
      if (file_done) begin
         // stream already closed: every beat is ignored by the block
         repeat (beats) send_beat(1'($urandom), 8'($urandom));
         return;
      end
      while (beats_sent - start < beats) begin
         build_command();
         emit_command();
      end
   endtask

   // Ends a full file: end command, clean end of stream, or a stream cut in
   // the middle of a command. Trailing beats must all be ignored.
   task automatic end_file();
      int pick;
      int cut;
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
         cmd_bytes.delete();
         cmd_bytes.push_back(CmdEnd);
         emit_command();
      end else if (pick == 1) begin
         send_beat(1'b1, 8'($urandom));
      end else begin
         build_command();
         cut = $urandom_range(0, cmd_bytes.size() - 1);
         for (int i = 0; i < cut; i++) send_beat(1'b0, cmd_bytes[i]);
         send_beat(1'b1, 8'($urandom));
      end
      file_done = 1'b1;
      repeat (NoiseBeats) send_beat(1'($urandom), 8'($urandom));
   endtask

   initial begin
      case ($urandom_range(0, 11))
         0:       plan = PlanBadSignature;
         1:       plan = PlanShortStream;
         default: plan = PlanFullFile;
      endcase
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls often
      write_codes(8'hFF, 8'h00);
      send_idle_pct = 23;
      stall_pct     = 48;
      send_header();
      if (!file_done)
         foreach (DirectedBytes[i]) send_beat(1'b0, DirectedBytes[i]);
      feed_random(PhaseBeats - DirectedLen);
      settle();

      // phase 2: roles swapped
      write_codes(8'($urandom), 8'($urandom));
      send_idle_pct = 48;
      stall_pct     = 23;
      feed_random(PhaseBeats);
      settle();

      // phase 3: full rate both ways, then close the file
      write_codes(8'h00, 8'hFF);
      send_idle_pct = 0;
      stall_pct     = 0;
      feed_random(PhaseBeats);
      if (!file_done) end_file();
      settle();

      if (ledger.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
